// ===== src/fat16_cluster_chain_engine_core_macros.svh =====
// assertion macros for the cluster chain engine
`ifndef FAT16_CLUSTER_CHAIN_ENGINE_CORE_MACROS_SVH
`define FAT16_CLUSTER_CHAIN_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error("check failed");
`define FCE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error("check failed");
`else
`define FCE_ASSERT(lbl, clk, rstn, prop)
`define FCE_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/fce_pkg.sv =====
// ----------------------------------------------------------------------------
// fce_pkg
// shared codes and types of the cluster chain engine
// ----------------------------------------------------------------------------
`default_nettype none
package fce_pkg;
  typedef logic [2:0]  op_t;
  typedef logic [1:0]  status_t;
  typedef logic [15:0] word_t;

  localparam op_t OP_LOAD  = 3'd0;
  localparam op_t OP_READ  = 3'd1;
  localparam op_t OP_ALLOC = 3'd2;
  localparam op_t OP_EXT   = 3'd3;
  localparam op_t OP_NEXT  = 3'd4;
  localparam op_t OP_FREE  = 3'd5;
  localparam op_t OP_TRUNC = 3'd6;
  localparam op_t OP_SEEK  = 3'd7;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_LOOP  = 2'd3;

  localparam word_t END_MARK  = 16'hFFFF;
  localparam word_t FREE_MARK = 16'h0000;
endpackage
`default_nettype wire

// ===== src/fce_if.sv =====
// ----------------------------------------------------------------------------
// fce channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none
interface fce_in_if;
  logic                valid;
  logic                ready;
  fce_pkg::op_t        op;
  fce_pkg::word_t      cluster;
  fce_pkg::word_t      entry_value;
  fce_pkg::word_t      hop_count;
  modport source (output valid, op, cluster, entry_value, hop_count, input ready);
  modport sink   (input valid, op, cluster, entry_value, hop_count, output ready);
endinterface

interface fce_out_if;
  logic                valid;
  logic                ready;
  fce_pkg::word_t      result_cluster;
  fce_pkg::status_t    status;
  modport source (output valid, result_cluster, status, input ready);
  modport sink   (input valid, result_cluster, status, output ready);
endinterface
`default_nettype wire

// ===== src/fat16_cluster_chain_engine_core.sv =====
// ----------------------------------------------------------------------------
// fat16_cluster_chain_engine_core
// cluster chain engine over a 16-bit file allocation table
// ----------------------------------------------------------------------------
// One request at a time, one result per request. After reset all
// TABLE_ENTRIES table entries are cleared, one entry per cycle, before the
// first request is taken. Load writes the entry, read fetches it, allocate
// scans for the first free entry, extend also links it behind the given
// cluster, and chain walks (free, truncate, seek) go one link at a time. The
// result sits in an output register while the next request is being worked
// on; a request finishing while it is still held waits.
`default_nettype none
`include "fat16_cluster_chain_engine_core_macros.svh"
module fat16_cluster_chain_engine_core #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  fce_in_if.sink           in_req,
  fce_out_if.source        out_rsp
);
  import fce_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] TE = 17'(TABLE_ENTRIES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_LINK  = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_FREEW = 4'd6;
  localparam logic [3:0] S_TEND  = 4'd7;
  localparam logic [3:0] S_SEEK  = 4'd8;
  localparam logic [3:0] S_SEEKW = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [12:0] cfg_r;
  op_t         op_r, op_nxt;
  word_t       cl_r, cl_nxt;
  word_t       hops_r, hops_nxt;
  word_t       cur_r, cur_nxt;
  word_t       got_r, got_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  word_t       res_r, res_nxt;
  status_t     st_r, st_nxt;
  logic [16:0] clr_r, clr_nxt;
  logic        ov_r;
  word_t       ores_r;
  status_t     ost_r;

  logic [16:0] lim;
  word_t       in_idx, idx_r, cur_idx;
  logic        accept, out_free;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  word_t         mem_wdata, mem_rdata;

  fce_table #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_table (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign lim      = ({4'b0, cfg_r} > TE) ? TE : {4'b0, cfg_r};
  assign in_idx   = in_req.cluster + 16'd1;
  assign idx_r    = cl_r + 16'd1;
  assign cur_idx  = cur_r + 16'd1;
  assign in_req.ready = (state_r == S_IDLE);
  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !ov_r || out_rsp.ready;
  assign out_rsp.valid = ov_r;
  assign out_rsp.result_cluster = ores_r;
  assign out_rsp.status = ost_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cl_nxt = cl_r;
    hops_nxt = hops_r;
    cur_nxt = cur_r;
    got_nxt = got_r;
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    res_nxt = res_r;
    st_nxt = st_r;
    clr_nxt = clr_r;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = FREE_MARK;
    mem_re = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r[AW-1:0];
        clr_nxt = clr_r + 17'd1;
        if (clr_r == TE - 17'd1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_req.op;
          cl_nxt = in_req.cluster;
          hops_nxt = in_req.hop_count;
          cur_nxt = in_req.cluster;
          cnt_nxt = '0;
          pend_nxt = 1'b0;
          res_nxt = '0;
          st_nxt = ST_OK;
          case (in_req.op)
            OP_LOAD: begin
              state_nxt = S_FIN;
              if ({1'b0, in_req.cluster} < lim) begin
                mem_we = 1'b1;
                mem_waddr = in_req.cluster[AW-1:0];
                mem_wdata = in_req.entry_value;
                res_nxt = in_req.entry_value;
              end else begin
                st_nxt = ST_RANGE;
              end
            end
            OP_ALLOC: state_nxt = S_SCAN;
            OP_FREE:  state_nxt = S_FREE;
            OP_SEEK:  state_nxt = S_SEEK;
            OP_EXT: begin
              if ({1'b0, in_idx} < lim) begin
                state_nxt = S_SCAN;
              end else begin
                st_nxt = ST_RANGE;
                state_nxt = S_FIN;
              end
            end
            default: begin
              if ({1'b0, in_idx} < lim) begin
                mem_re = 1'b1;
                mem_raddr = in_idx[AW-1:0];
                state_nxt = S_RD;
              end else begin
                st_nxt = ST_RANGE;
                state_nxt = S_FIN;
              end
            end
          endcase
        end
      end
      S_RD: begin
        case (op_r)
          OP_READ: begin
            res_nxt = mem_rdata;
            state_nxt = S_FIN;
          end
          OP_NEXT: begin
            if (mem_rdata != END_MARK) begin
              res_nxt = mem_rdata;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            cur_nxt = mem_rdata;
            state_nxt = S_FREE;
          end
        endcase
      end
      S_SCAN: begin
        if (pend_r && mem_rdata == FREE_MARK) begin
          mem_we = 1'b1;
          mem_waddr = pidx_r;
          mem_wdata = END_MARK;
          got_nxt = 16'(pidx_r) - 16'd1;
          if (op_r == OP_ALLOC) begin
            res_nxt = 16'(pidx_r) - 16'd1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LINK;
          end
        end else if (cnt_r < lim) begin
          mem_re = 1'b1;
          mem_raddr = cnt_r[AW-1:0];
          pidx_nxt = cnt_r[AW-1:0];
          pend_nxt = 1'b1;
          cnt_nxt = cnt_r + 17'd1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          st_nxt = ST_FULL;
          state_nxt = S_FIN;
        end
      end
      S_LINK: begin
        mem_we = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = got_r;
        res_nxt = got_r;
        state_nxt = S_FIN;
      end
      S_FREE: begin
        if (cur_r == END_MARK || cnt_r >= lim || {1'b0, cur_idx} >= lim) begin
          if (cur_r == END_MARK) begin
            st_nxt = ST_OK;
          end else if (cnt_r >= lim) begin
            st_nxt = ST_LOOP;
          end else begin
            st_nxt = ST_RANGE;
          end
          state_nxt = (op_r == OP_TRUNC) ? S_TEND : S_FIN;
        end else begin
          mem_re = 1'b1;
          mem_raddr = cur_idx[AW-1:0];
          state_nxt = S_FREEW;
        end
      end
      S_FREEW: begin
        mem_we = 1'b1;
        mem_waddr = cur_idx[AW-1:0];
        mem_wdata = FREE_MARK;
        cur_nxt = mem_rdata;
        cnt_nxt = cnt_r + 17'd1;
        state_nxt = S_FREE;
      end
      S_TEND: begin
        mem_we = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = END_MARK;
        state_nxt = S_FIN;
      end
      S_SEEK: begin
        res_nxt = cur_r;
        if (cnt_r >= {1'b0, hops_r}) begin
          state_nxt = S_FIN;
        end else if (cnt_r >= lim) begin
          st_nxt = ST_LOOP;
          state_nxt = S_FIN;
        end else if ({1'b0, cur_idx} >= lim) begin
          st_nxt = ST_RANGE;
          state_nxt = S_FIN;
        end else begin
          mem_re = 1'b1;
          mem_raddr = cur_idx[AW-1:0];
          state_nxt = S_SEEKW;
        end
      end
      S_SEEKW: begin
        cur_nxt = mem_rdata;
        cnt_nxt = cnt_r + 17'd1;
        if (mem_rdata == END_MARK) begin
          res_nxt = mem_rdata;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SEEK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cfg_r <= 13'd4096;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pend_r <= pend_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (state_r == S_FIN && out_free) begin
        ov_r <= 1'b1;
      end else if (out_rsp.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cl_r <= cl_nxt;
    hops_r <= hops_nxt;
    cur_r <= cur_nxt;
    got_r <= got_nxt;
    cnt_r <= cnt_nxt;
    pidx_r <= pidx_nxt;
    res_r <= res_nxt;
    st_r <= st_nxt;
    if (state_r == S_FIN && out_free) begin
      ores_r <= res_r;
      ost_r <= st_r;
    end
  end

  // same-entry read and write never overlap in one cycle
  `FCE_NEVER(a_no_rw_clash, clk, rst_n, mem_re && mem_we && mem_raddr == mem_waddr)
  `FCE_ASSERT(a_clear_zero, clk, rst_n, (state_r == S_CLR) |-> (mem_we && mem_wdata == FREE_MARK))
  `FCE_ASSERT(a_busy_after_req, clk, rst_n, accept |=> (state_r != S_IDLE))
endmodule
`default_nettype wire

// ===== src/fce_table.sv =====
// ----------------------------------------------------------------------------
// fce_table
// allocation table storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fce_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
